// ===== rtl/core/pslc_pkg.sv =====
`default_nettype none

package pslc_pkg;

  localparam int unsigned TagLen = 18;
  localparam int unsigned KeyLen = 10;

  localparam int unsigned TagCntW = $clog2(TagLen + 1);
  localparam int unsigned KeyCntW = $clog2(KeyLen + 1);

  localparam logic [7:0] TAG_TEXT [TagLen] = '{
    8'h23, 8'h45, 8'h58, 8'h54, 8'h2D, 8'h58, 8'h2D, 8'h53, 8'h54,
    8'h52, 8'h45, 8'h41, 8'h4D, 8'h2D, 8'h49, 8'h4E, 8'h46, 8'h3A
  };

  localparam logic [7:0] KEY_TEXT [KeyLen] = '{
    8'h42, 8'h41, 8'h4E, 8'h44, 8'h57, 8'h49, 8'h44, 8'h54, 8'h48, 8'h3D
  };

  localparam logic [7:0] CHR_LF    = 8'd10;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'd9;
  localparam logic [7:0] CHR_CR    = 8'd13;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;

  // Largest magnitude that still fits: the most negative 32-bit value
  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

  typedef enum logic [2:0] {
    CLS_KEPT       = 3'd0,
    CLS_TAG_OK     = 3'd1,
    CLS_URI        = 3'd2,
    CLS_EMPTY      = 3'd3,
    CLS_NO_KEY     = 3'd4,
    CLS_NO_DIGITS  = 3'd5,
    CLS_RANGE      = 3'd6
  } line_class_e;

endpackage

`default_nettype wire

// ===== rtl/core/pslc_in_if.sv =====
`default_nettype none

interface pslc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       new_playlist;

  modport source (output valid, output byte_value, output new_playlist, input ready);
  modport sink   (input valid, input byte_value, input new_playlist, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pslc_out_if.sv =====
`default_nettype none

interface pslc_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  line_class;
  logic signed [31:0] bandwidth;

  modport source (output valid, output line_class, output bandwidth, input ready);
  modport sink   (input valid, input line_class, input bandwidth, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/playlist_stream_line_classifier_core.sv =====
`default_nettype none
// A line feed transfer puts its result on res_o in the cycle after it.
// The core takes one byte per cycle while the result register is free or being
//   drained; the byte parse and the multiply by ten feed the line state registers.
// Reset (asynchronous, active low) clears all line and pending state and
//   empties the result register.

module playlist_stream_line_classifier_core
  import pslc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pslc_in_if.sink     in_i,
  pslc_out_if.source  res_o
);

  // Number parser phase: before sign, after sign, in digits, finished
  typedef enum logic [1:0] {
    NUM_WS     = 2'd0,
    NUM_SIGNED = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_DONE   = 2'd3
  } num_phase_e;

  // Line and pending state
  logic               uri_pending_q, uri_pending_d;
  logic [31:0]        held_bw_q, held_bw_d;
  logic [TagCntW-1:0] tag_cnt_q, tag_cnt_d;
  logic               tag_seen_q, tag_seen_d;
  logic [KeyCntW-1:0] key_cnt_q, key_cnt_d;
  logic               key_seen_q, key_seen_d;
  num_phase_e         phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [31:0]        mag_q, mag_d;
  logic               has_digit_q, has_digit_d;
  logic               ovf_q, ovf_d;
  logic               nonempty_q, nonempty_d;

  // Result register
  logic               res_valid_q, res_valid_d;
  line_class_e        res_cls_q, res_cls_d;
  logic [31:0]        res_bw_q, res_bw_d;

  // Working copy of the state after an optional playlist restart
  logic               c_uri_pending;
  logic [31:0]        c_held_bw;
  logic [TagCntW-1:0] c_tag_cnt;
  logic               c_tag_seen;
  logic [KeyCntW-1:0] c_key_cnt;
  logic               c_key_seen;
  num_phase_e         c_phase;
  logic               c_neg;
  logic [31:0]        c_mag;
  logic               c_has_digit;
  logic               c_ovf;
  logic               c_nonempty;

  logic               xfer;
  logic [7:0]         b;
  logic               is_digit;
  logic               is_space;
  logic [35:0]        mag_next;

  // Accept whenever the result register is free or being drained
  assign in_i.ready = !res_valid_q || res_o.ready;
  assign xfer       = in_i.valid && in_i.ready;
  assign b          = in_i.byte_value;

  assign is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
  assign is_space = (b == CHR_SPACE) || ((b >= CHR_TAB) && (b <= CHR_CR));

  // mag * 10 + digit as two shifts and adds
  assign mag_next = ({4'd0, c_mag} << 3) + ({4'd0, c_mag} << 1) + {28'd0, b - CHR_ZERO};

  always_comb begin
    // Restart clears everything before this byte is looked at
    if (in_i.new_playlist) begin
      c_uri_pending = 1'b0;
      c_held_bw     = '0;
      c_tag_cnt     = '0;
      c_tag_seen    = 1'b0;
      c_key_cnt     = '0;
      c_key_seen    = 1'b0;
      c_phase       = NUM_WS;
      c_neg         = 1'b0;
      c_mag         = '0;
      c_has_digit   = 1'b0;
      c_ovf         = 1'b0;
      c_nonempty    = 1'b0;
    end else begin
      c_uri_pending = uri_pending_q;
      c_held_bw     = held_bw_q;
      c_tag_cnt     = tag_cnt_q;
      c_tag_seen    = tag_seen_q;
      c_key_cnt     = key_cnt_q;
      c_key_seen    = key_seen_q;
      c_phase       = phase_q;
      c_neg         = neg_q;
      c_mag         = mag_q;
      c_has_digit   = has_digit_q;
      c_ovf         = ovf_q;
      c_nonempty    = nonempty_q;
    end
  end

  always_comb begin
    uri_pending_d = uri_pending_q;
    held_bw_d     = held_bw_q;
    tag_cnt_d     = tag_cnt_q;
    tag_seen_d    = tag_seen_q;
    key_cnt_d     = key_cnt_q;
    key_seen_d    = key_seen_q;
    phase_d       = phase_q;
    neg_d         = neg_q;
    mag_d         = mag_q;
    has_digit_d   = has_digit_q;
    ovf_d         = ovf_q;
    nonempty_d    = nonempty_q;
    res_cls_d     = res_cls_q;
    res_bw_d      = res_bw_q;
    res_valid_d   = res_valid_q && !res_o.ready;

    if (xfer) begin
      uri_pending_d = c_uri_pending;
      held_bw_d     = c_held_bw;
      tag_cnt_d     = c_tag_cnt;
      tag_seen_d    = c_tag_seen;
      key_cnt_d     = c_key_cnt;
      key_seen_d    = c_key_seen;
      phase_d       = c_phase;
      neg_d         = c_neg;
      mag_d         = c_mag;
      has_digit_d   = c_has_digit;
      ovf_d         = c_ovf;
      nonempty_d    = c_nonempty;

      if (b != CHR_LF) begin
        nonempty_d = 1'b1;

        // Tag search; a mismatch restarts at one if the byte opens the tag
        if (!c_tag_seen) begin
          if (b == TAG_TEXT[c_tag_cnt]) begin
            tag_cnt_d = c_tag_cnt + 1'b1;
          end else begin
            tag_cnt_d = (b == TAG_TEXT[0]) ? TagCntW'(1) : '0;
          end
          tag_seen_d = (tag_cnt_d == TagCntW'(TagLen));
        end

        if (c_key_seen) begin
          // Number after the key: whitespace, sign, then digits
          if (c_phase == NUM_WS && is_space) begin
            phase_d = NUM_WS;
          end else if (c_phase == NUM_WS && (b == CHR_PLUS || b == CHR_MINUS)) begin
            neg_d   = (b == CHR_MINUS);
            phase_d = NUM_SIGNED;
          end else if (c_phase != NUM_DONE && is_digit) begin
            phase_d     = NUM_DIGITS;
            has_digit_d = 1'b1;
            if (!c_ovf) begin
              if (mag_next > MAG_LIMIT) begin
                ovf_d = 1'b1;
              end else begin
                mag_d = mag_next[31:0];
              end
            end
          end else begin
            phase_d = NUM_DONE;
          end
        end else begin
          if (b == KEY_TEXT[c_key_cnt]) begin
            key_cnt_d = c_key_cnt + 1'b1;
          end else begin
            key_cnt_d = (b == KEY_TEXT[0]) ? KeyCntW'(1) : '0;
          end
          key_seen_d = (key_cnt_d == KeyCntW'(KeyLen));
        end
      end else begin
        // Line feed: classify the line, then drop all line state
        res_valid_d = 1'b1;
        res_bw_d    = '0;
        if (c_uri_pending) begin
          res_cls_d     = CLS_URI;
          res_bw_d      = c_held_bw;
          uri_pending_d = 1'b0;
        end else if (c_tag_seen) begin
          if (!c_key_seen) begin
            res_cls_d = CLS_NO_KEY;
          end else if (!c_has_digit) begin
            res_cls_d = CLS_NO_DIGITS;
          end else if (c_ovf || (!c_neg && c_mag == MAG_LIMIT[31:0])) begin
            res_cls_d = CLS_RANGE;
          end else begin
            res_cls_d     = CLS_TAG_OK;
            res_bw_d      = c_neg ? (32'd0 - c_mag) : c_mag;
            held_bw_d     = res_bw_d;
            uri_pending_d = 1'b1;
          end
        end else if (!c_nonempty) begin
          res_cls_d = CLS_EMPTY;
        end else begin
          res_cls_d = CLS_KEPT;
        end

        tag_cnt_d   = '0;
        tag_seen_d  = 1'b0;
        key_cnt_d   = '0;
        key_seen_d  = 1'b0;
        phase_d     = NUM_WS;
        neg_d       = 1'b0;
        mag_d       = '0;
        has_digit_d = 1'b0;
        ovf_d       = 1'b0;
        nonempty_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uri_pending_q <= 1'b0;
      held_bw_q     <= '0;
      tag_cnt_q     <= '0;
      tag_seen_q    <= 1'b0;
      key_cnt_q     <= '0;
      key_seen_q    <= 1'b0;
      phase_q       <= NUM_WS;
      neg_q         <= 1'b0;
      mag_q         <= '0;
      has_digit_q   <= 1'b0;
      ovf_q         <= 1'b0;
      nonempty_q    <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      uri_pending_q <= uri_pending_d;
      held_bw_q     <= held_bw_d;
      tag_cnt_q     <= tag_cnt_d;
      tag_seen_q    <= tag_seen_d;
      key_cnt_q     <= key_cnt_d;
      key_seen_q    <= key_seen_d;
      phase_q       <= phase_d;
      neg_q         <= neg_d;
      mag_q         <= mag_d;
      has_digit_q   <= has_digit_d;
      ovf_q         <= ovf_d;
      nonempty_q    <= nonempty_d;
      res_valid_q   <= res_valid_d;
    end
  end

  // Result payload: hold until the next line feed transfer
  always_ff @(posedge clk_i) begin
    res_cls_q <= res_cls_d;
    res_bw_q  <= res_bw_d;
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.line_class = res_cls_q;
  assign res_o.bandwidth  = res_bw_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
  import pslc_pkg::*;

  // One classification per line feed: the class and the bandwidth it carries
  typedef struct packed {
    line_class_e        cls;
    logic signed [31:0] bw;
  } line_result_t;

  // Progress of the decimal after the key
  typedef enum logic [1:0] {
    NUM_LEAD,    // skipping whitespace, sign still allowed
    NUM_SIGNED,  // sign taken, digits only
    NUM_DIGITS,  // inside the digit run
    NUM_DONE     // any later byte is ignored
  } num_phase_e;

  // Directed stimulus: one playlist line per row, line feed appended by the loop.
  // A caret in the text stands for a zero byte. Where typed is set, the row's
  // result is the one written here; otherwise the predictor decides.
  typedef struct {
    string              text;
    bit                 fresh;
    bit                 typed;
    line_class_e        cls;
    logic signed [31:0] bw;
  } dir_row_t;

  localparam int unsigned NumDirRows  = 25;
  localparam int unsigned RandomBytes = 480;
  localparam int unsigned DrainCycles = 8;

  dir_row_t dir_rows [NumDirRows] = '{
    '{"", 1'b1, 1'b1, CLS_EMPTY, 32'h0000_0000},
    '{"#EXTM3U", 1'b0, 1'b1, CLS_KEPT, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=2147483647,RESOLUTION=1x1",
      1'b0, 1'b1, CLS_TAG_OK, 32'h7FFF_FFFF},
    '{"", 1'b0, 1'b1, CLS_URI, 32'h7FFF_FFFF},
    '{"#EXT-X-STREAM-INF:CODECS=\"a\",BANDWIDTH=-2147483648",
      1'b0, 1'b1, CLS_TAG_OK, 32'h8000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=5", 1'b0, 1'b1, CLS_URI, 32'h8000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=2147483648", 1'b0, 1'b1, CLS_RANGE, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=-2147483649", 1'b0, 1'b1, CLS_RANGE, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=000099999999999999999999",
      1'b0, 1'b1, CLS_RANGE, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:RESOLUTION=1x1", 1'b0, 1'b1, CLS_NO_KEY, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=,9", 1'b0, 1'b1, CLS_NO_DIGITS, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=+-5", 1'b0, 1'b1, CLS_NO_DIGITS, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH= \011\013\014\015+00123 45",
      1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"uri/a.m3u8\015", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"\015", 1'b0, 1'b1, CLS_KEPT, 32'h0000_0000},
    '{"BANDWIDTH=77 #EXT-X-STREAM-INF:", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"lo.m3u8", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=12^34", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"plain", 1'b1, 1'b1, CLS_KEPT, 32'h0000_0000},
    '{"##EXT-X-STREAM-INF:BBANDWIDTH=0", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"x", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"#EXT-X-STREAM-INF:BANDWIDTH=-0", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"", 1'b1, 1'b1, CLS_EMPTY, 32'h0000_0000},
    '{"\377\200 #EXT-X-STREAM-INF:BANDWIDTH=\0118,", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000},
    '{"a", 1'b0, 1'b0, CLS_KEPT, 32'h0000_0000}
  };

  string edge_values [8] = '{
    "2147483647", "2147483648", "-2147483648", "-2147483649",
    "+2147483647", "-0", "4294967306", "+0"
  };

  string other_lines [6] = '{
    "#EXTM3U", "#EXT-X-VERSION:6", "#EXT-X-STREAM-IN", "BANDWIDTH=100",
    "#EXT-X-MEDIA:TYPE=AUDIO", "#EXT-X-INDEPENDENT-SEGMENTS"
  };

  logic clk = 1'b0;
  logic rst_n;

  pslc_in_if  in_bus ();
  pslc_out_if res_bus ();

  playlist_stream_line_classifier_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .res_o  (res_bus)
  );

  always #4 clk = ~clk;

  // Predictor state: a private copy of the line and pending registers
  logic               uri_due;
  logic signed [31:0] held_bw;
  int unsigned        tag_cnt;
  logic               tag_hit;
  int unsigned        key_cnt;
  logic               key_hit;
  num_phase_e         num_phase;
  logic               num_neg;
  logic [31:0]        num_mag;
  logic               num_digit;
  logic               num_ovf;
  logic               line_used;

  line_result_t line_results_due [$];
  logic [7:0]   line_buf [$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned errors         = 0;

  function automatic void clear_line_state();
    tag_cnt   = 0;
    tag_hit   = 1'b0;
    key_cnt   = 0;
    key_hit   = 1'b0;
    num_phase = NUM_LEAD;
    num_neg   = 1'b0;
    num_mag   = '0;
    num_digit = 1'b0;
    num_ovf   = 1'b0;
    line_used = 1'b0;
  endfunction

  function automatic void clear_playlist_state();
    uri_due = 1'b0;
    held_bw = '0;
    clear_line_state();
  endfunction

  // Feed one byte of the number that follows the key
  function automatic void take_number_byte(input logic [7:0] b);
    logic        is_digit;
    logic [35:0] grown;
    is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
    if (num_phase == NUM_LEAD) begin
      if (b == CHR_SPACE || (b >= CHR_TAB && b <= CHR_CR)) return;
      if (b == CHR_PLUS || b == CHR_MINUS) begin
        num_neg   = (b == CHR_MINUS);
        num_phase = NUM_SIGNED;
        return;
      end
    end
    if (num_phase != NUM_DONE && is_digit) begin
      num_phase = NUM_DIGITS;
      num_digit = 1'b1;
      if (!num_ovf) begin
        grown = {4'b0, num_mag} * 36'd10 + {28'b0, b - CHR_ZERO};
        if (grown > MAG_LIMIT) num_ovf = 1'b1;
        else num_mag = grown[31:0];
      end
      return;
    end
    num_phase = NUM_DONE;
  endfunction

  // Advance the predictor by one accepted byte; return 1 where a line ends
  function automatic bit classify_byte(input logic [7:0] b, input bit fresh,
                                       output line_result_t r);
    r = '{CLS_KEPT, 32'sd0};
    if (fresh) clear_playlist_state();

    if (b != CHR_LF) begin
      line_used = 1'b1;
      if (!tag_hit) begin
        if (b == TAG_TEXT[tag_cnt]) tag_cnt++;
        else tag_cnt = (b == TAG_TEXT[0]) ? 1 : 0;
        if (tag_cnt >= TagLen) tag_hit = 1'b1;
      end
      if (key_hit) begin
        take_number_byte(b);
      end else begin
        if (b == KEY_TEXT[key_cnt]) key_cnt++;
        else key_cnt = (b == KEY_TEXT[0]) ? 1 : 0;
        if (key_cnt >= KeyLen) key_hit = 1'b1;
      end
      return 1'b0;
    end

    if (uri_due) begin
      // The line after an accepted tag is its URI, whatever it holds
      r       = '{CLS_URI, held_bw};
      uri_due = 1'b0;
    end else if (tag_hit) begin
      if (!key_hit) r.cls = CLS_NO_KEY;
      else if (!num_digit) r.cls = CLS_NO_DIGITS;
      else if (num_ovf || (!num_neg && num_mag == MAG_LIMIT[31:0])) r.cls = CLS_RANGE;
      else begin
        r.cls   = CLS_TAG_OK;
        r.bw    = num_neg ? -num_mag : num_mag;
        held_bw = r.bw;
        uri_due = 1'b1;
      end
    end else if (!line_used) begin
      r.cls = CLS_EMPTY;
    end
    clear_line_state();
    return 1'b1;
  endfunction

  // Offer one byte at the falling edge, with random idle cycles before it,
  // and hold it until the block takes the transfer
  task automatic send_byte(input logic [7:0] b, input bit fresh, input bit typed,
                           input line_result_t typed_res);
    line_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid        = 1'b1;
    in_bus.byte_value   = b;
    in_bus.new_playlist = fresh;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (classify_byte(b, fresh, r)) begin
      line_results_due = {line_results_due, (typed ? typed_res : r)};
    end
    bytes_sent++;
  endtask

  // Append text to the line under construction; map caret to a zero byte on request
  task automatic put_text(input string s, input bit map_zero);
    foreach (s[i]) line_buf = {line_buf, ((map_zero && s[i] == 8'h5E) ? 8'h00 : s[i])};
  endtask

  // Send the line under construction; new_playlist rides on its first byte
  task automatic send_line(input bit fresh, input bit with_lf, input bit typed,
                           input line_result_t typed_res);
    foreach (line_buf[i]) send_byte(line_buf[i], fresh && i == 0, 1'b0, typed_res);
    if (with_lf) send_byte(CHR_LF, fresh && line_buf.size() == 0, typed, typed_res);
    line_buf.delete();
  endtask

  // Receiver: stall at random, decided at each falling edge
  always @(negedge clk) begin
    res_bus.ready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    line_result_t due;
    if (rst_n && res_bus.valid && res_bus.ready) begin
      if (line_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual class %0d bw %0d",
                 $time, res_bus.line_class, res_bus.bandwidth);
        errors++;
      end else begin
        due = line_results_due.pop_front();
        if (res_bus.line_class !== due.cls) begin
          $display("%0t: line_class mismatch, expected %0d, actual %0d",
                   $time, due.cls, res_bus.line_class);
          errors++;
        end
        if (res_bus.bandwidth !== due.bw) begin
          $display("%0t: bandwidth mismatch, expected %0d, actual %0d",
                   $time, due.bw, res_bus.bandwidth);
          errors++;
        end
      end
    end
  end

  // Guard against a hang anywhere in the run
  initial begin
    #3_200_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    line_result_t typed_res;
    int unsigned  dir_bytes;
    int unsigned  kind;
    int unsigned  pick;
    int unsigned  phase;
    int unsigned  n;
    logic [7:0]   ws;
    bit           fresh;
    bit           force_fresh;
    bit           with_lf;

    // Hold every input at a known value through reset
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.byte_value   = '0;
    in_bus.new_playlist = 1'b0;
    clear_playlist_state();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed part: extremes, every class and the corner cases, no idling
    foreach (dir_rows[i]) begin
      typed_res = '{dir_rows[i].cls, dir_rows[i].bw};
      put_text(dir_rows[i].text, 1'b1);
      send_line(dir_rows[i].fresh, 1'b1, dir_rows[i].typed, typed_res);
    end
    dir_bytes   = bytes_sent;
    force_fresh = 1'b0;

    // Random part: mostly well-formed stream tags and URIs, the rest noise
    while (bytes_sent - dir_bytes < RandomBytes) begin
      // Walk the idling phases: none, sender idle, receiver stalling, both
      phase = (bytes_sent - dir_bytes) * 4 / RandomBytes;
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
        default: begin src_idle_pct = 11; sink_stall_pct = 11; end
      endcase

      fresh       = force_fresh || ($urandom_range(99) < 5);
      force_fresh = 1'b0;
      kind        = $urandom_range(99);

      if (kind < 45) begin
        // Stream tag line, sometimes with junk before it or a broken tag
        if ($urandom_range(9) == 0) put_text("x,", 1'b0);
        pick = $urandom_range(19);
        if (pick == 0) put_text("#EXT-X-STREAM-INF;", 1'b0);
        else if (pick == 1) put_text("#EXT-X-STREAM-IN#EXT-X-STREAM-INF:", 1'b0);
        else put_text("#EXT-X-STREAM-INF:", 1'b0);
        pick = $urandom_range(5);
        if (pick == 0) put_text("CODECS=\"avc1.4d401f\",", 1'b0);
        else if (pick == 1) put_text("AVERAGE-BANDWIDTH=900,", 1'b0);
        else if (pick == 2) put_text("RESOLUTION=1280x720,", 1'b0);
        pick = $urandom_range(11);
        if (pick == 1) put_text("BANDWDTH=", 1'b0);
        else if (pick == 2) put_text("BANDWIDTH", 1'b0);
        else if (pick == 3) put_text("BANDBANDWIDTH=", 1'b0);
        else if (pick != 0) put_text("BANDWIDTH=", 1'b0);
        // Leading whitespace drawn from space and tab to carriage return
        if ($urandom_range(4) == 0) begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            ws = 8'($urandom_range(8, 13));
            if (ws == 8'd8) ws = CHR_SPACE;
            else if (ws == CHR_LF) ws = CHR_TAB;
            line_buf = {line_buf, ws};
          end
        end
        pick = $urandom_range(7);
        case (pick)
          0, 1, 2: begin
            n = $urandom_range(4);
            if (n == 0) put_text("+", 1'b0);
            else if (n == 1) put_text("-", 1'b0);
            put_text($sformatf("%0d", $urandom_range(0, 10000000)), 1'b0);
          end
          3: put_text($sformatf("%0d", $signed($urandom)), 1'b0);
          4: put_text(edge_values[$urandom_range(7)], 1'b0);
          5: begin
            if ($urandom_range(1) == 0) put_text("-", 1'b0);
            n = $urandom_range(10, 14);
            repeat (n) line_buf = {line_buf, CHR_ZERO + 8'($urandom_range(9))};
          end
          6: begin
            n = $urandom_range(3);
            if (n == 1) put_text("+", 1'b0);
            else if (n == 2) put_text("-x", 1'b0);
            else if (n == 3) put_text(" ,", 1'b0);
          end
          default: put_text("00000000000042", 1'b0);
        endcase
        pick = $urandom_range(4);
        if (pick == 0) put_text(",RESOLUTION=640x360", 1'b0);
        else if (pick == 1) put_text("\015", 1'b0);
        else if (pick == 2) put_text(" 17", 1'b0);
      end else if (kind < 65) begin
        put_text($sformatf("seg/%0d.m3u8", $urandom_range(0, 99999)), 1'b0);
        if ($urandom_range(4) == 0) put_text("\015", 1'b0);
      end else if (kind < 75) begin
        put_text(other_lines[$urandom_range(5)], 1'b0);
      end else if (kind >= 85) begin
        // Noise: any byte, a line feed among them included
        n = $urandom_range(0, 24);
        repeat (n) line_buf = {line_buf, 8'($urandom_range(255))};
      end

      // Now and then abandon the line and start a new playlist instead
      with_lf = ($urandom_range(99) >= 4);
      if (!with_lf) force_fresh = 1'b1;
      send_line(fresh, with_lf, 1'b0, typed_res);
    end

    // Drop valid and let the last results drain
    @(negedge clk);
    in_bus.valid   = 1'b0;
    sink_stall_pct = 0;
    while (line_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== playlist_stream_line_classifier_core.f =====
rtl/core/pslc_pkg.sv
rtl/core/pslc_in_if.sv
rtl/core/pslc_out_if.sv
rtl/core/playlist_stream_line_classifier_core.sv
tb/sv/tb.sv
